### rtl/pidaw_pkg.sv
package pidaw_pkg;

   localparam int GAIN_W     = 24;
   localparam int AW_W       = 16;
   localparam int FORCE_W    = 24;
   localparam int SPEED_W    = 16;
   localparam int STEP_W     = 15;
   localparam int ERR_W      = 17;
   localparam int DERR_W     = 18;
   localparam int INTEG_W    = 40;
   localparam int MUL_A_W    = 25;
   localparam int MUL_B_W    = 21;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int ACC_W      = 72;
   localparam int RAW_W      = 53;
   localparam int DIFF_W     = 54;
   localparam int CORR_W     = 54;
   localparam int ISUM_W     = 56;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 24'd3276800;
   localparam logic [GAIN_W-1:0]  INT_GAIN_RST   = 24'd1638;
   localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = 24'd8192000;
   localparam logic [AW_W-1:0]    AW_GAIN_RST    = 16'd10486;
   localparam logic [FORCE_W-1:0] FORCE_MAX_RST  = 24'd1280000;
   localparam logic [FORCE_W-1:0] FORCE_MIN_RST  = 24'd0;
   localparam logic [SPEED_W-1:0] TARGET_RST     = 16'd2560;
   localparam logic [STEP_W-1:0]  RAMP_STEP_RST  = 15'd5;

   typedef enum logic [2:0] {
      REG_PROP_GAIN,
      REG_INT_GAIN,
      REG_DERIV_GAIN,
      REG_AW_GAIN,
      REG_FORCE_MAX,
      REG_FORCE_MIN,
      REG_TARGET_SPEED,
      REG_RAMP_STEP
   } csr_index_type;

   // weight of a partial product in the accumulator
   typedef enum logic [1:0] {
      SH_0,
      SH_18,
      SH_20,
      SH_36
   } shift_type;

endpackage

### rtl/pid_with_antiwindup_and_ramp.sv
// Speed loop PID with reference ramp and back-calculation anti-windup.
// Input channel (req_valid/req_ready/req_measured_speed): one Q7.8 speed
// word per control tick. Result channel (rsp_*): clamped force, ramped
// reference, error and the two limit flags, one word per input word.
// APB port (psel..prdata, pready tied high): gains, aw gain, force
// limits, target and ramp step at byte addresses 4*i; reads return them.
// req_ready is high only while idle, so a new word is taken only after the
// previous one has been finished and handed to the output register. The
// work is done by one shared 25x21 multiplier and 72-bit accumulator
// stepping through seven partial products (four for the PID sum, three for
// the anti-windup term) plus ramp, error, clamp and update steps.
// If the receiver stalls, the output register holds the word; a following
// word is computed up to its final update step and waits there.
// Synchronous reset restores the register defaults and clears the
// reference, last error and integral; there is no clearing pass.
module pid_with_antiwindup_and_ramp
   import pidaw_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [SPEED_W-1:0]    req_measured_speed,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [FORCE_W-1:0]    rsp_drive_force,
   output logic signed [SPEED_W-1:0]    rsp_reference_speed,
   output logic signed [ERR_W-1:0]      rsp_speed_error,
   output logic                         rsp_at_upper_limit,
   output logic                         rsp_at_lower_limit,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [CSR_ADDR_W-1:0]        paddr,
   input  logic [CSR_DATA_W-1:0]        pwdata,
   output logic [CSR_DATA_W-1:0]        prdata,
   output logic                         pready
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RAMP,
      ST_ERROR,
      ST_P_MUL,
      ST_D_MUL,
      ST_IL_MUL,
      ST_IH_MUL,
      ST_SUM,
      ST_CLAMP,
      ST_A0_MUL,
      ST_A1_MUL,
      ST_A2_MUL,
      ST_AW_SUM,
      ST_UPDATE
   } state_type;

   state_type                  state_ff, state_in;

   logic [GAIN_W-1:0]          prop_gain_ff, prop_gain_in;
   logic [GAIN_W-1:0]          int_gain_ff, int_gain_in;
   logic [GAIN_W-1:0]          deriv_gain_ff, deriv_gain_in;
   logic [AW_W-1:0]            aw_gain_ff, aw_gain_in;
   logic signed [FORCE_W-1:0]  force_max_ff, force_max_in;
   logic signed [FORCE_W-1:0]  force_min_ff, force_min_in;
   logic signed [SPEED_W-1:0]  target_ff, target_in;
   logic [STEP_W-1:0]          ramp_step_ff, ramp_step_in;

   logic signed [SPEED_W-1:0]  ref_ff, ref_in;
   logic signed [ERR_W-1:0]    last_err_ff, last_err_in;
   logic signed [INTEG_W-1:0]  integ_ff, integ_in;

   logic signed [SPEED_W-1:0]  meas_ff, meas_in;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic signed [DERR_W-1:0]   derr_ff, derr_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   shift_type                  prod_sh_ff, prod_sh_in;
   logic                       prod_en_ff, prod_en_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [FORCE_W-1:0]  clamped_ff, clamped_in;
   logic                       up_ff, up_in;
   logic                       low_ff, low_in;
   logic signed [DIFF_W-1:0]   diff_ff, diff_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [FORCE_W-1:0]  rsp_force_ff, rsp_force_in;
   logic signed [SPEED_W-1:0]  rsp_ref_ff, rsp_ref_in;
   logic signed [ERR_W-1:0]    rsp_err_ff, rsp_err_in;
   logic                       rsp_up_ff, rsp_up_in;
   logic                       rsp_low_ff, rsp_low_in;

   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   product;
   logic signed [ACC_W-1:0]    prod_ext;
   logic signed [ACC_W-1:0]    prod_shifted;

   logic signed [ERR_W-1:0]    delta;
   logic signed [ERR_W-1:0]    step_pos;
   logic signed [ERR_W-1:0]    step_neg;
   logic                       in_reach;
   logic signed [SPEED_W-1:0]  ref_step_next;
   logic signed [ERR_W-1:0]    err_calc;
   logic signed [DERR_W-1:0]   derr_calc;
   logic signed [RAW_W-1:0]    raw;
   logic signed [RAW_W-1:0]    fmax_ext;
   logic signed [RAW_W-1:0]    fmin_ext;
   logic                       raw_above;
   logic                       raw_below;
   logic signed [FORCE_W-1:0]  clamp_sel;
   logic signed [CORR_W-1:0]   corr;
   logic signed [ISUM_W-1:0]   isum;
   logic signed [INTEG_W-1:0]  isum_sat;

   logic                       csr_write;
   csr_index_type              csr_index;
   logic                       req_accept;
   logic                       rsp_accept;
   logic                       rsp_free;

   assign req_accept = req_valid && req_ready;
   assign rsp_accept = rsp_valid_ff && rsp_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   assign csr_write  = psel && penable && pwrite;
   assign csr_index  = csr_index_type'(paddr[CSR_ADDR_W-1:2]);

   // shared multiplier
   assign product    = mul_a * mul_b;
   assign prod_ext   = ACC_W'(prod_ff);

   always_comb begin
      case (prod_sh_ff)
         SH_0:    prod_shifted = prod_ext;
         SH_18:   prod_shifted = prod_ext <<< 18;
         SH_20:   prod_shifted = prod_ext <<< 20;
         SH_36:   prod_shifted = prod_ext <<< 36;
         default: prod_shifted = prod_ext;
      endcase
   end

   // reference ramp
   assign delta    = ERR_W'(target_ff) - ERR_W'(ref_ff);
   assign step_pos = $signed({2'b00, ramp_step_ff});
   assign step_neg = -step_pos;
   assign in_reach = (delta <= step_pos) && (delta >= step_neg);
   assign ref_step_next = delta[ERR_W-1] ? (ref_ff - $signed({1'b0, ramp_step_ff}))
                                         : (ref_ff + $signed({1'b0, ramp_step_ff}));

   assign err_calc  = ERR_W'(ref_ff) - ERR_W'(meas_ff);
   assign derr_calc = DERR_W'(err_ff) - DERR_W'(last_err_ff);

   // clamp: raw = floor(acc / 2^12)
   assign raw       = acc_ff[RAW_W+11:12];
   assign fmax_ext  = RAW_W'(force_max_ff);
   assign fmin_ext  = RAW_W'(force_min_ff);
   assign raw_above = raw > fmax_ext;
   assign raw_below = raw < fmin_ext;
   assign clamp_sel = raw_above ? force_max_ff :
                      raw_below ? force_min_ff : raw[FORCE_W-1:0];

   // integral update with back-calculation, saturated to 40 bits
   assign corr = acc_ff[CORR_W+15:16];
   assign isum = ISUM_W'(integ_ff) + ISUM_W'(err_ff) + ISUM_W'(corr);
   assign isum_sat = (isum[ISUM_W-1:INTEG_W-1] == {(ISUM_W-INTEG_W+1){isum[ISUM_W-1]}})
                     ? isum[INTEG_W-1:0]
                     : (isum[ISUM_W-1] ? $signed({1'b1, {(INTEG_W-1){1'b0}}})
                                       : $signed({1'b0, {(INTEG_W-1){1'b1}}}));

   always_comb begin
      state_in      = state_ff;
      prop_gain_in  = prop_gain_ff;
      int_gain_in   = int_gain_ff;
      deriv_gain_in = deriv_gain_ff;
      aw_gain_in    = aw_gain_ff;
      force_max_in  = force_max_ff;
      force_min_in  = force_min_ff;
      target_in     = target_ff;
      ramp_step_in  = ramp_step_ff;
      ref_in        = ref_ff;
      last_err_in   = last_err_ff;
      integ_in      = integ_ff;
      meas_in       = meas_ff;
      err_in        = err_ff;
      derr_in       = derr_ff;
      prod_in       = product;
      prod_sh_in    = SH_0;
      prod_en_in    = 1'b0;
      acc_in        = prod_en_ff ? (acc_ff + prod_shifted) : acc_ff;
      clamped_in    = clamped_ff;
      up_in         = up_ff;
      low_in        = low_ff;
      diff_in       = diff_ff;
      rsp_valid_in  = rsp_accept ? 1'b0 : rsp_valid_ff;
      rsp_force_in  = rsp_force_ff;
      rsp_ref_in    = rsp_ref_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_up_in     = rsp_up_ff;
      rsp_low_in    = rsp_low_ff;
      mul_a         = '0;
      mul_b         = '0;

      if (csr_write) begin
         unique case (csr_index)
            REG_PROP_GAIN:    prop_gain_in  = pwdata[GAIN_W-1:0];
            REG_INT_GAIN:     int_gain_in   = pwdata[GAIN_W-1:0];
            REG_DERIV_GAIN:   deriv_gain_in = pwdata[GAIN_W-1:0];
            REG_AW_GAIN:      aw_gain_in    = pwdata[AW_W-1:0];
            REG_FORCE_MAX:    force_max_in  = pwdata[FORCE_W-1:0];
            REG_FORCE_MIN:    force_min_in  = pwdata[FORCE_W-1:0];
            REG_TARGET_SPEED: target_in     = pwdata[SPEED_W-1:0];
            REG_RAMP_STEP:    ramp_step_in  = pwdata[STEP_W-1:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               meas_in  = req_measured_speed;
               state_in = ST_RAMP;
            end
         end
         ST_RAMP: begin
            ref_in   = in_reach ? target_ff : ref_step_next;
            state_in = ST_ERROR;
         end
         ST_ERROR: begin
            err_in   = err_calc;
            state_in = ST_P_MUL;
         end
         ST_P_MUL: begin
            derr_in    = derr_calc;
            mul_a      = $signed({1'b0, prop_gain_ff});
            mul_b      = MUL_B_W'(err_ff);
            prod_en_in = 1'b1;
            acc_in     = '0;
            state_in   = ST_D_MUL;
         end
         ST_D_MUL: begin
            mul_a      = $signed({1'b0, deriv_gain_ff});
            mul_b      = MUL_B_W'(derr_ff);
            prod_en_in = 1'b1;
            state_in   = ST_IL_MUL;
         end
         ST_IL_MUL: begin
            mul_a      = $signed({1'b0, int_gain_ff});
            mul_b      = $signed({1'b0, integ_ff[19:0]});
            prod_en_in = 1'b1;
            state_in   = ST_IH_MUL;
         end
         ST_IH_MUL: begin
            mul_a      = $signed({1'b0, int_gain_ff});
            mul_b      = $signed({integ_ff[INTEG_W-1], integ_ff[INTEG_W-1:20]});
            prod_sh_in = SH_20;
            prod_en_in = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            clamped_in = clamp_sel;
            up_in      = raw_above;
            low_in     = !raw_above && raw_below;
            diff_in    = DIFF_W'(clamp_sel) - DIFF_W'(raw);
            state_in   = ST_A0_MUL;
         end
         ST_A0_MUL: begin
            mul_a      = $signed({{(MUL_A_W-AW_W){1'b0}}, aw_gain_ff});
            mul_b      = $signed({3'b000, diff_ff[17:0]});
            prod_en_in = 1'b1;
            acc_in     = '0;
            state_in   = ST_A1_MUL;
         end
         ST_A1_MUL: begin
            mul_a      = $signed({{(MUL_A_W-AW_W){1'b0}}, aw_gain_ff});
            mul_b      = $signed({3'b000, diff_ff[35:18]});
            prod_sh_in = SH_18;
            prod_en_in = 1'b1;
            state_in   = ST_A2_MUL;
         end
         ST_A2_MUL: begin
            mul_a      = $signed({{(MUL_A_W-AW_W){1'b0}}, aw_gain_ff});
            mul_b      = MUL_B_W'($signed(diff_ff[DIFF_W-1:36]));
            prod_sh_in = SH_36;
            prod_en_in = 1'b1;
            state_in   = ST_AW_SUM;
         end
         ST_AW_SUM: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (rsp_free) begin
               integ_in     = isum_sat;
               last_err_in  = err_ff;
               rsp_valid_in = 1'b1;
               rsp_force_in = clamped_ff;
               rsp_ref_in   = ref_ff;
               rsp_err_in   = err_ff;
               rsp_up_in    = up_ff;
               rsp_low_in   = low_ff;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prop_gain_ff  <= PROP_GAIN_RST;
         int_gain_ff   <= INT_GAIN_RST;
         deriv_gain_ff <= DERIV_GAIN_RST;
         aw_gain_ff    <= AW_GAIN_RST;
         force_max_ff  <= FORCE_MAX_RST;
         force_min_ff  <= FORCE_MIN_RST;
         target_ff     <= TARGET_RST;
         ramp_step_ff  <= RAMP_STEP_RST;
         ref_ff        <= '0;
         last_err_ff   <= '0;
         integ_ff      <= '0;
         prod_en_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prop_gain_ff  <= prop_gain_in;
         int_gain_ff   <= int_gain_in;
         deriv_gain_ff <= deriv_gain_in;
         aw_gain_ff    <= aw_gain_in;
         force_max_ff  <= force_max_in;
         force_min_ff  <= force_min_in;
         target_ff     <= target_in;
         ramp_step_ff  <= ramp_step_in;
         ref_ff        <= ref_in;
         last_err_ff   <= last_err_in;
         integ_ff      <= integ_in;
         prod_en_ff    <= prod_en_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      meas_ff      <= meas_in;
      err_ff       <= err_in;
      derr_ff      <= derr_in;
      prod_ff      <= prod_in;
      prod_sh_ff   <= prod_sh_in;
      acc_ff       <= acc_in;
      clamped_ff   <= clamped_in;
      up_ff        <= up_in;
      low_ff       <= low_in;
      diff_ff      <= diff_in;
      rsp_force_ff <= rsp_force_in;
      rsp_ref_ff   <= rsp_ref_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_up_ff    <= rsp_up_in;
      rsp_low_ff   <= rsp_low_in;
   end

   always_comb begin
      unique case (csr_index)
         REG_PROP_GAIN:    prdata = CSR_DATA_W'(prop_gain_ff);
         REG_INT_GAIN:     prdata = CSR_DATA_W'(int_gain_ff);
         REG_DERIV_GAIN:   prdata = CSR_DATA_W'(deriv_gain_ff);
         REG_AW_GAIN:      prdata = CSR_DATA_W'(aw_gain_ff);
         REG_FORCE_MAX:    prdata = CSR_DATA_W'(force_max_ff);
         REG_FORCE_MIN:    prdata = CSR_DATA_W'(force_min_ff);
         REG_TARGET_SPEED: prdata = CSR_DATA_W'(target_ff);
         REG_RAMP_STEP:    prdata = CSR_DATA_W'(ramp_step_ff);
      endcase
   end

   assign pready              = 1'b1;
   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive_force     = rsp_force_ff;
   assign rsp_reference_speed = rsp_ref_ff;
   assign rsp_speed_error     = rsp_err_ff;
   assign rsp_at_upper_limit  = rsp_up_ff;
   assign rsp_at_lower_limit  = rsp_low_ff;

   a_valid_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("result word appeared outside the update step");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_up_ff && rsp_low_ff))
      else $error("both limit flags set");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_ready)
      else $error("input taken while a word is in progress");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_force_ff) && $stable(rsp_err_ff))
      else $error("stalled result word changed");

endmodule

### dv/pidaw_monitor.sv
`timescale 1ns / 100ps

module pidaw_monitor
   import pidaw_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic signed [SPEED_W-1:0] req_measured_speed,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [FORCE_W-1:0] rsp_drive_force,
   input  logic signed [SPEED_W-1:0] rsp_reference_speed,
   input  logic signed [ERR_W-1:0]   rsp_speed_error,
   input  logic                      rsp_at_upper_limit,
   input  logic                      rsp_at_lower_limit,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic                      pready,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   output int                        fail_count,
   output int                        outstanding,
   output int                        results_seen,
   output int                        upper_hits,
   output int                        lower_hits
);

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic signed [FORCE_W-1:0] force_out;
      logic signed [SPEED_W-1:0] ref_out;
      logic signed [ERR_W-1:0]   err_out;
      logic                      upper;
      logic                      lower;
   } tick_out_type;

   localparam wide_type INTEG_HI = 128'sd549755813887;
   localparam wide_type INTEG_LO = -128'sd549755813888;

   // register copies
   logic        [GAIN_W-1:0]  kp_r, ki_r, kd_r;
   logic        [AW_W-1:0]    kaw_r;
   logic signed [FORCE_W-1:0] fmax_r, fmin_r;
   logic signed [SPEED_W-1:0] target_r;
   logic        [STEP_W-1:0]  step_r;

   // loop state
   logic signed [SPEED_W-1:0] ref_r;
   logic signed [ERR_W-1:0]   last_err_r;
   logic signed [INTEG_W-1:0] integ_r;

   tick_out_type force_expect_q[$];

   function automatic tick_out_type control_tick(logic signed [SPEED_W-1:0] meas);
      wide_type delta, step, nref, err, pd, itrm, raw, clamped, corr, isum;
      wide_type kp, ki, kd, kaw, fmax, fmin;
      tick_out_type r;
      kp   = $signed({1'b0, kp_r});
      ki   = $signed({1'b0, ki_r});
      kd   = $signed({1'b0, kd_r});
      kaw  = $signed({1'b0, kaw_r});
      fmax = fmax_r;
      fmin = fmin_r;
      step = $signed({1'b0, step_r});

      delta = target_r - ref_r;
      if (delta <= step && delta >= -step) begin
         ref_r = target_r;
      end else if (delta > 0) begin
         nref  = ref_r + step;
         ref_r = nref[SPEED_W-1:0];
      end else begin
         nref  = ref_r - step;
         ref_r = nref[SPEED_W-1:0];
      end

      err  = ref_r - meas;
      pd   = kp * err + kd * (err - last_err_r);
      itrm = ki * integ_r;
      raw  = (itrm + pd) >>> 12;

      r.upper = 1'b0;
      r.lower = 1'b0;
      if (raw > fmax) begin
         clamped = fmax;
         r.upper = 1'b1;
      end else if (raw < fmin) begin
         clamped = fmin;
         r.lower = 1'b1;
      end else begin
         clamped = raw;
      end

      corr = (kaw * (clamped - raw)) >>> 16;
      isum = integ_r + err + corr;
      if (isum > INTEG_HI) isum = INTEG_HI;
      if (isum < INTEG_LO) isum = INTEG_LO;
      integ_r    = isum[INTEG_W-1:0];
      last_err_r = err[ERR_W-1:0];

      r.force_out = clamped[FORCE_W-1:0];
      r.ref_out   = ref_r;
      r.err_out   = err[ERR_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      tick_out_type want, got;
      if (reset) begin
         kp_r         = PROP_GAIN_RST;
         ki_r         = INT_GAIN_RST;
         kd_r         = DERIV_GAIN_RST;
         kaw_r        = AW_GAIN_RST;
         fmax_r       = FORCE_MAX_RST;
         fmin_r       = FORCE_MIN_RST;
         target_r     = TARGET_RST;
         step_r       = RAMP_STEP_RST;
         ref_r        = '0;
         last_err_r   = '0;
         integ_r      = '0;
         fail_count   = 0;
         results_seen = 0;
         upper_hits   = 0;
         lower_hits   = 0;
         force_expect_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (csr_index_type'(paddr[4:2]))
               REG_PROP_GAIN:    kp_r     = pwdata[GAIN_W-1:0];
               REG_INT_GAIN:     ki_r     = pwdata[GAIN_W-1:0];
               REG_DERIV_GAIN:   kd_r     = pwdata[GAIN_W-1:0];
               REG_AW_GAIN:      kaw_r    = pwdata[AW_W-1:0];
               REG_FORCE_MAX:    fmax_r   = pwdata[FORCE_W-1:0];
               REG_FORCE_MIN:    fmin_r   = pwdata[FORCE_W-1:0];
               REG_TARGET_SPEED: target_r = pwdata[SPEED_W-1:0];
               REG_RAMP_STEP:    step_r   = pwdata[STEP_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            want = control_tick(req_measured_speed);
            if (want.upper) upper_hits++;
            if (want.lower) lower_hits++;
            force_expect_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            got = {rsp_drive_force, rsp_reference_speed, rsp_speed_error,
                   rsp_at_upper_limit, rsp_at_lower_limit};
            if (force_expect_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result word with nothing expected: force %0d ref %0d err %0d",
                           $time, got.force_out, got.ref_out, got.err_out);
            end else begin
               want = force_expect_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $write("%0t: mismatch: exp force %0d ref %0d err %0d up %0b low %0b",
                            $time, want.force_out, want.ref_out, want.err_out,
                            want.upper, want.lower);
                     $display(" / got force %0d ref %0d err %0d up %0b low %0b",
                              got.force_out, got.ref_out, got.err_out,
                              got.upper, got.lower);
                  end
               end
            end
         end
      end
      outstanding <= force_expect_q.size();
   end

endmodule

### dv/pid_with_antiwindup_and_ramp_tb.sv
`timescale 1ns / 100ps

module pid_with_antiwindup_and_ramp_tb;
   import pidaw_pkg::*;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [SPEED_W-1:0] req_measured_speed = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b1;
   logic signed [FORCE_W-1:0] rsp_drive_force;
   logic signed [SPEED_W-1:0] rsp_reference_speed;
   logic signed [ERR_W-1:0]   rsp_speed_error;
   logic                      rsp_at_upper_limit;
   logic                      rsp_at_lower_limit;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]     paddr = '0;
   logic [CSR_DATA_W-1:0]     pwdata = '0;
   logic [CSR_DATA_W-1:0]     prdata;
   logic                      pready;

   int fail_count, outstanding, results_seen, upper_hits, lower_hits;
   int words_sent = 0;
   int reg_writes = 0;
   logic signed [SPEED_W-1:0] cur_target = TARGET_RST;

   // receiver stall pattern
   int unsigned stall_mode = 0;
   int unsigned mode_left  = 0;
   int unsigned hold_left  = 0;

   always #4 clock = ~clock;

   pid_with_antiwindup_and_ramp dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_measured_speed  (req_measured_speed),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_drive_force     (rsp_drive_force),
      .rsp_reference_speed (rsp_reference_speed),
      .rsp_speed_error     (rsp_speed_error),
      .rsp_at_upper_limit  (rsp_at_upper_limit),
      .rsp_at_lower_limit  (rsp_at_lower_limit),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   pidaw_monitor pid_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_measured_speed  (req_measured_speed),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_drive_force     (rsp_drive_force),
      .rsp_reference_speed (rsp_reference_speed),
      .rsp_speed_error     (rsp_speed_error),
      .rsp_at_upper_limit  (rsp_at_upper_limit),
      .rsp_at_lower_limit  (rsp_at_lower_limit),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .pready              (pready),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .fail_count          (fail_count),
      .outstanding         (outstanding),
      .results_seen        (results_seen),
      .upper_hits          (upper_hits),
      .lower_hits          (lower_hits)
   );

   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         mode_left  <= $urandom_range(20, 200);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (hold_left == 0) begin
               rsp_ready <= ~rsp_ready;
               hold_left <= $urandom_range(0, 24);
            end else begin
               hold_left <= hold_left - 1;
            end
         end
      endcase
   end

   // all tasks are entered just after a rising edge
   task automatic send_word(logic [SPEED_W-1:0] speed);
      req_valid          <= 1'b1;
      req_measured_speed <= speed;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic idle_gap(int unsigned cycles);
      if (cycles > 0) begin
         req_valid          <= 1'b0;
         req_measured_speed <= $urandom();
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] value);
      logic [31:0] junk;
      junk = $urandom();
      // bits above the register width must be ignored
      if ($urandom_range(0, 3) == 0) begin
         case (idx)
            REG_AW_GAIN, REG_TARGET_SPEED: value[31:16] = junk[31:16];
            REG_RAMP_STEP:                 value[31:15] = junk[31:15];
            default:                       value[31:24] = junk[31:24];
         endcase
      end
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      reg_writes++;
   endtask

   task automatic program_regs(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                               logic [31:0] kaw, logic [31:0] fmax, logic [31:0] fmin,
                               logic [31:0] tgt, logic [31:0] step);
      drain();
      csr_write(REG_PROP_GAIN, kp);
      csr_write(REG_INT_GAIN, ki);
      csr_write(REG_DERIV_GAIN, kd);
      csr_write(REG_AW_GAIN, kaw);
      csr_write(REG_FORCE_MAX, fmax);
      csr_write(REG_FORCE_MIN, fmin);
      csr_write(REG_TARGET_SPEED, tgt);
      csr_write(REG_RAMP_STEP, step);
      cur_target = tgt[SPEED_W-1:0];
   endtask

   initial begin
      logic [31:0] kp, ki, kd, kaw, fmax, fmin, tgt, step;
      logic [SPEED_W-1:0] speed;
      int unsigned style, count, burst, pick;
      bit drained;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, speed extremes and alternating bits
      send_word(16'h8000);
      send_word(16'h7FFF);
      send_word(16'h0000);
      send_word(16'hFFFF);
      send_word(16'h5555);
      send_word(16'hAAAA);

      // zero gains with both limits at zero: raw sits on the limits, no flag
      program_regs(0, 0, 0, 0, 0, 0, 32'h7FFF, 32'h7FFF);
      send_word(16'h0000);
      send_word(16'h0064);
      // zero step: reference holds, then holds because it equals the target
      program_regs(0, 0, 0, 0, 0, 0, 32'hFFFF_8000, 0);
      send_word(16'h1234);
      program_regs(0, 0, 0, 0, 0, 0, 32'h7FFF, 0);
      send_word(16'hEDCB);
      // full-scale ramp down, landing on the target
      program_regs(4096, 0, 0, 0, 32'h7FFFFF, 32'h800000, 32'hFFFF_8000, 32'h7FFF);
      send_word(16'h0000);
      send_word(16'h0000);
      send_word(16'h0000);
      // crossed limits: upper test wins, else lower
      program_regs(4096, 0, 0, 0, -1000, 1000, 0, 32'h7FFF);
      send_word(16'h0000);
      send_word(-16'sd2000);
      send_word(16'sd2000);
      // max gains with crossed full-scale limits drive the integral to saturation
      program_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 32'h800000, 32'h7FFFFF,
                   32'h7FFF, 32'h7FFF);
      repeat (3) begin
         send_word(16'h8000);
         send_word(16'h7FFF);
      end

      for (int ph = 0; ph < 12; ph++) begin
         style = (ph == 0) ? 3 : $urandom_range(0, 2);
         case (style)
            0: begin
               kp   = $urandom_range(0, 24'h7FFFFF);
               ki   = $urandom_range(0, 8192);
               kd   = $urandom_range(0, 24'hFFFFFF);
               kaw  = $urandom_range(0, 16'hFFFF);
               fmax = $urandom_range(0, 24'h7FFFFF);
               fmin = -$urandom_range(0, 24'h7FFFFF);
               tgt  = $urandom();
               step = $urandom_range(0, 64);
            end
            1: begin
               kp   = $urandom();
               ki   = $urandom();
               kd   = $urandom();
               kaw  = $urandom();
               fmax = $urandom();
               fmin = $urandom();
               tgt  = $urandom();
               step = $urandom();
            end
            2: begin
               kp   = $urandom_range(0, 1) ? 24'hFFFFFF : 0;
               ki   = $urandom_range(0, 1) ? 24'hFFFFFF : 0;
               kd   = $urandom_range(0, 1) ? 24'hFFFFFF : 0;
               kaw  = $urandom_range(0, 1) ? 16'hFFFF : 0;
               fmax = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
               fmin = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
               tgt  = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
               step = $urandom_range(0, 1) ? 15'h7FFF : 0;
            end
            default: begin
               kp   = PROP_GAIN_RST;
               ki   = INT_GAIN_RST;
               kd   = DERIV_GAIN_RST;
               kaw  = AW_GAIN_RST;
               fmax = FORCE_MAX_RST;
               fmin = FORCE_MIN_RST;
               tgt  = TARGET_RST;
               step = RAMP_STEP_RST;
            end
         endcase
         program_regs(kp, ki, kd, kaw, fmax, fmin, tgt, step);

         drained = 1'b0;
         count   = 0;
         while (count < 36) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && count < 36; b++) begin
               pick = $urandom_range(0, 9);
               if (pick < 5)
                  speed = cur_target + $signed(16'($urandom_range(0, 1024)) - 16'sd512);
               else if (pick < 8)
                  speed = $urandom();
               else
                  case ($urandom_range(0, 3))
                     0: speed = 16'h8000;
                     1: speed = 16'h7FFF;
                     2: speed = 16'h0000;
                     default: speed = 16'hFFFF;
                  endcase
               send_word(speed);
               count++;
            end
            // hold off mid-phase until every result is back
            if (ph % 4 == 1 && !drained && count >= 18) begin
               drain();
               drained = 1'b1;
            end else if ($urandom_range(0, 2) != 0) begin
               idle_gap($urandom_range(1, 25));
            end
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d speed words across %0d register writes; %0d results checked.",
               words_sent, reg_writes, results_seen);
      $display("Force clamped high %0d times and low %0d times.", upper_hits, lower_hits);
      if (fail_count == 0 && outstanding == 0)
         $display("PASS pid_with_antiwindup_and_ramp");
      else
         $display("FAIL pid_with_antiwindup_and_ramp");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Timed out with %0d results still outstanding.", outstanding);
      $display("FAIL pid_with_antiwindup_and_ramp");
      $finish;
   end

endmodule
